// ===== hw/rtl/door_open_timeout_clock_defines.svh =====
// assertion macros for the door clock
`ifndef DOOR_OPEN_TIMEOUT_CLOCK_DEFINES_SVH
`define DOOR_OPEN_TIMEOUT_CLOCK_DEFINES_SVH

// checked on every clock edge outside reset
`define DOTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// checked on every clock edge, reset included
`define DOTC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hw/rtl/dotc_pkg.sv =====
`default_nettype none

package dotc_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // button ladder thresholds
  localparam logic [7:0] LVL_NONE   = 8'd230;
  localparam logic [7:0] LVL_SELECT = 8'd180;
  localparam logic [7:0] LVL_LEFT   = 8'd130;
  localparam logic [7:0] LVL_DOWN   = 8'd80;
  localparam logic [7:0] LVL_UP     = 8'd30;

  localparam logic [6:0] SEC_PER_MIN = 7'd60;
  localparam logic [4:0] HOUR_TOP    = 5'd12;
  localparam logic [3:0] HOUR_MAX    = 4'd12;
  localparam logic [3:0] HOUR_MIN    = 4'd1;
  localparam logic [2:0] TENS_MAX    = 3'd5;
  localparam logic [3:0] ONES_MAX    = 4'd9;
  localparam logic [4:0] ONES_WRAP   = 5'd10;
  localparam logic [3:0] TENS_WRAP   = 4'd6;
  localparam logic [3:0] DOOR_MIN_MAX = 4'd9;
  localparam logic [5:0] CLOSE_CNT_MAX = 6'd63;

  typedef enum logic [2:0] {
    REG_WIN_START   = 3'd0,
    REG_WIN_END     = 3'd1,
    REG_WIN_PM      = 3'd2,
    REG_CLOSED_LVL  = 3'd3,
    REG_OPEN_LIMIT  = 3'd4,
    REG_CLOSE_DUR   = 3'd5
  } dotc_reg_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } dotc_req_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_OPEN    = 2'd1,
    MODE_CLOSING = 2'd2
  } dotc_mode_t;

  typedef enum logic [1:0] {
    CUR_HOUR = 2'd0,
    CUR_TENS = 2'd1,
    CUR_ONES = 2'd2,
    CUR_HALF = 2'd3
  } dotc_cursor_t;

  typedef enum logic [2:0] {
    BTN_NONE,
    BTN_SELECT,
    BTN_LEFT,
    BTN_DOWN,
    BTN_UP,
    BTN_RIGHT
  } dotc_btn_t;

  typedef struct packed {
    logic [3:0] win_start;
    logic [3:0] win_end;
    logic       win_pm;
    logic [7:0] closed_level;
    logic [3:0] open_limit;
    logic [5:0] close_dur;
  } dotc_cfg_t;

  typedef struct packed {
    dotc_req_t  req_type;
    logic [7:0] adc_level;
  } dotc_item_t;

  typedef struct packed {
    logic         set_done;
    logic [3:0]   hour;
    logic [2:0]   min_tens;
    logic [3:0]   min_ones;
    logic         pm;
    logic [5:0]   sec;
    dotc_cursor_t cursor;
    dotc_mode_t   mode;
    logic [3:0]   door_min;
    logic [2:0]   door_tens;
    logic [3:0]   door_ones;
    logic [5:0]   close_count;
  } dotc_state_t;

  function automatic dotc_btn_t decode_button(input logic [7:0] level);
    dotc_btn_t btn;
    if (level > LVL_NONE) begin
      btn = BTN_NONE;
    end else if (level > LVL_SELECT) begin
      btn = BTN_SELECT;
    end else if (level > LVL_LEFT) begin
      btn = BTN_LEFT;
    end else if (level > LVL_DOWN) begin
      btn = BTN_DOWN;
    end else if (level > LVL_UP) begin
      btn = BTN_UP;
    end else begin
      btn = BTN_RIGHT;
    end
    return btn;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dotc_cfg.sv =====
`default_nettype none

module dotc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dotc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [dotc_pkg::DATA_W-1:0]  pwdata,
  output logic      [dotc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output dotc_pkg::dotc_cfg_t               cfg
);

  dotc_pkg::dotc_reg_t reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = dotc_pkg::dotc_reg_t'(paddr[dotc_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_start    <= 4'd6;
      cfg.win_end      <= 4'd10;
      cfg.win_pm       <= 1'b0;
      cfg.closed_level <= 8'd130;
      cfg.open_limit   <= 4'd10;
      cfg.close_dur    <= 6'd5;
    end else if (wr_en) begin
      unique case (reg_sel)
        dotc_pkg::REG_WIN_START:  cfg.win_start    <= pwdata[3:0];
        dotc_pkg::REG_WIN_END:    cfg.win_end      <= pwdata[3:0];
        dotc_pkg::REG_WIN_PM:     cfg.win_pm       <= pwdata[0];
        dotc_pkg::REG_CLOSED_LVL: cfg.closed_level <= pwdata[7:0];
        dotc_pkg::REG_OPEN_LIMIT: cfg.open_limit   <= pwdata[3:0];
        dotc_pkg::REG_CLOSE_DUR:  cfg.close_dur    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      dotc_pkg::REG_WIN_START:  prdata[3:0] = cfg.win_start;
      dotc_pkg::REG_WIN_END:    prdata[3:0] = cfg.win_end;
      dotc_pkg::REG_WIN_PM:     prdata[0]   = cfg.win_pm;
      dotc_pkg::REG_CLOSED_LVL: prdata[7:0] = cfg.closed_level;
      dotc_pkg::REG_OPEN_LIMIT: prdata[3:0] = cfg.open_limit;
      dotc_pkg::REG_CLOSE_DUR:  prdata[5:0] = cfg.close_dur;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dotc_core.sv =====
`default_nettype none

`include "door_open_timeout_clock_defines.svh"

module dotc_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire dotc_pkg::dotc_item_t item,
  input  wire dotc_pkg::dotc_cfg_t  cfg,
  output dotc_pkg::dotc_state_t     st_next
);

  dotc_pkg::dotc_state_t st;
  dotc_pkg::dotc_btn_t   btn;
  logic                  in_window;
  logic [4:0]            hour_sum;
  logic [6:0]            sec_sum;
  logic [4:0]            ones_sum;
  logic [4:0]            door_ones_sum;
  logic [3:0]            door_tens_sum;
  logic [4:0]            door_min_sum;
  logic [5:0]            close_inc;

  assign btn       = dotc_pkg::decode_button(item.adc_level);
  assign in_window = (st.hour >= cfg.win_start) && (st.hour <= cfg.win_end) &&
                     (st.pm == cfg.win_pm);
  assign hour_sum      = {1'b0, st.hour} + 5'd1;
  assign sec_sum       = {1'b0, st.sec} + 7'd1;
  assign ones_sum      = {1'b0, st.min_ones} + 5'd1;
  assign door_ones_sum = {1'b0, st.door_ones} + 5'd1;
  assign door_tens_sum = {1'b0, st.door_tens} + 4'd1;
  assign door_min_sum  = {1'b0, st.door_min} + 5'd1;
  assign close_inc     = (st.close_count < dotc_pkg::CLOSE_CNT_MAX) ?
                         st.close_count + 6'd1 : st.close_count;

  always_comb begin
    st_next = st;
    if (fire) begin
      if (item.req_type == dotc_pkg::REQ_SAMPLE) begin
        if (!st.set_done) begin
          unique case (btn)
            dotc_pkg::BTN_SELECT: st_next.set_done = 1'b1;
            dotc_pkg::BTN_LEFT: begin
              if (st.cursor != dotc_pkg::CUR_HOUR) begin
                st_next.cursor = dotc_pkg::dotc_cursor_t'(st.cursor - 2'd1);
              end
            end
            dotc_pkg::BTN_RIGHT: begin
              if (st.cursor != dotc_pkg::CUR_HALF) begin
                st_next.cursor = dotc_pkg::dotc_cursor_t'(st.cursor + 2'd1);
              end
            end
            dotc_pkg::BTN_UP: begin
              case (st.cursor)
                dotc_pkg::CUR_HOUR:
                  st_next.hour = (st.hour >= dotc_pkg::HOUR_MAX) ? dotc_pkg::HOUR_MIN :
                                 hour_sum[3:0];
                dotc_pkg::CUR_TENS:
                  st_next.min_tens = (st.min_tens >= dotc_pkg::TENS_MAX) ? 3'd0 :
                                     st.min_tens + 3'd1;
                dotc_pkg::CUR_ONES:
                  st_next.min_ones = (st.min_ones >= dotc_pkg::ONES_MAX) ? 4'd0 :
                                     ones_sum[3:0];
                default: st_next.pm = ~st.pm;
              endcase
            end
            dotc_pkg::BTN_DOWN: begin
              case (st.cursor)
                dotc_pkg::CUR_HOUR:
                  st_next.hour = (st.hour <= dotc_pkg::HOUR_MIN ||
                                  st.hour > dotc_pkg::HOUR_MAX) ?
                                 dotc_pkg::HOUR_MAX : st.hour - 4'd1;
                dotc_pkg::CUR_TENS:
                  st_next.min_tens = (st.min_tens == 3'd0 ||
                                      st.min_tens > dotc_pkg::TENS_MAX) ?
                                     dotc_pkg::TENS_MAX : st.min_tens - 3'd1;
                dotc_pkg::CUR_ONES:
                  st_next.min_ones = (st.min_ones == 4'd0 ||
                                      st.min_ones > dotc_pkg::ONES_MAX) ?
                                     dotc_pkg::ONES_MAX : st.min_ones - 4'd1;
                default: st_next.pm = ~st.pm;
              endcase
            end
            default: ;
          endcase
        end else if (st.mode != dotc_pkg::MODE_CLOSING) begin
          if (in_window && item.adc_level <= cfg.closed_level) begin
            st_next.mode = dotc_pkg::MODE_OPEN;
          end else begin
            st_next.mode = dotc_pkg::MODE_IDLE;
          end
        end
      end else if (st.set_done) begin
        // clock advance
        if (sec_sum < dotc_pkg::SEC_PER_MIN) begin
          st_next.sec = sec_sum[5:0];
        end else begin
          st_next.sec = 6'd0;
          if (ones_sum < dotc_pkg::ONES_WRAP) begin
            st_next.min_ones = ones_sum[3:0];
          end else begin
            st_next.min_ones = 4'd0;
            if (st.min_tens < dotc_pkg::TENS_MAX) begin
              st_next.min_tens = st.min_tens + 3'd1;
            end else begin
              st_next.min_tens = 3'd0;
              if (hour_sum == dotc_pkg::HOUR_TOP) begin
                st_next.hour = hour_sum[3:0];
                st_next.pm   = ~st.pm;
              end else if (hour_sum > dotc_pkg::HOUR_TOP) begin
                st_next.hour = dotc_pkg::HOUR_MIN;
              end else begin
                st_next.hour = hour_sum[3:0];
              end
            end
          end
        end
        // door timer
        unique case (st.mode)
          dotc_pkg::MODE_OPEN: begin
            if (door_ones_sum < dotc_pkg::ONES_WRAP) begin
              st_next.door_ones = door_ones_sum[3:0];
            end else begin
              st_next.door_ones = 4'd0;
              if (door_tens_sum < dotc_pkg::TENS_WRAP) begin
                st_next.door_tens = door_tens_sum[2:0];
              end else begin
                st_next.door_tens = 3'd0;
                if (door_min_sum >= {1'b0, cfg.open_limit} ||
                    st.door_min >= dotc_pkg::DOOR_MIN_MAX) begin
                  st_next.mode        = dotc_pkg::MODE_CLOSING;
                  st_next.close_count = 6'd0;
                  st_next.door_min    = 4'd0;
                end else begin
                  st_next.door_min = door_min_sum[3:0];
                end
              end
            end
          end
          dotc_pkg::MODE_CLOSING: begin
            st_next.door_min  = 4'd0;
            st_next.door_tens = 3'd0;
            st_next.door_ones = 4'd0;
            if (close_inc >= cfg.close_dur) begin
              st_next.mode        = dotc_pkg::MODE_IDLE;
              st_next.close_count = 6'd0;
            end else begin
              st_next.close_count = close_inc;
            end
          end
          default: begin
            st_next.door_min  = 4'd0;
            st_next.door_tens = 3'd0;
            st_next.door_ones = 4'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.set_done    <= 1'b0;
      st.hour        <= dotc_pkg::HOUR_MIN;
      st.min_tens    <= 3'd0;
      st.min_ones    <= 4'd0;
      st.pm          <= 1'b0;
      st.sec         <= 6'd0;
      st.cursor      <= dotc_pkg::CUR_HOUR;
      st.mode        <= dotc_pkg::MODE_IDLE;
      st.door_min    <= 4'd0;
      st.door_tens   <= 3'd0;
      st.door_ones   <= 4'd0;
      st.close_count <= 6'd0;
    end else begin
      st <= st_next;
    end
  end

  `DOTC_ASSERT(a_set_sticky, st.set_done |=> st.set_done)
  `DOTC_ASSERT(a_idle_before_set, !st.set_done |-> st.mode == dotc_pkg::MODE_IDLE)
  `DOTC_ASSERT(a_clock_held_before_set, !st.set_done |=> $stable(st.sec))
  `DOTC_ASSERT(a_closing_clears_timer,
               st.mode == dotc_pkg::MODE_CLOSING |->
               (st.door_min == 4'd0 && st.door_tens == 3'd0 && st.door_ones == 4'd0))

endmodule

`default_nettype wire

// ===== hw/rtl/door_open_timeout_clock.sv =====
// a request is first held in the input register; its result is then registered for the output
// throughput: one request per cycle while the output accepts every cycle
// an output stall holds back the input once one request waits in each register
// reset is synchronous and active high; it clears the clock, cursor, door
// timer and handshake state and restores the register defaults
`default_nettype none

module door_open_timeout_clock (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,  // adc_level
  input  wire logic                                 s_axis_tuser,  // req_type
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // hour, minute_tens, minute_ones, is_pm, second, clock_valid, cursor_field,
  // door_mode, open_minutes, open_sec_tens, open_sec_ones, zero fill
  output logic [dotc_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [dotc_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [dotc_pkg::DATA_W-1:0]          pwdata,
  output logic      [dotc_pkg::DATA_W-1:0]          prdata,
  output logic                                      pready
);

  dotc_pkg::dotc_cfg_t   cfg;
  dotc_pkg::dotc_item_t  in_item;
  dotc_pkg::dotc_state_t st_next;
  dotc_pkg::dotc_state_t res;
  logic                  in_valid;
  logic                  advance;
  logic                  fire;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.req_type  <= dotc_pkg::dotc_req_t'(s_axis_tuser);
      in_item.adc_level <= s_axis_tdata;
    end
    if (fire) begin
      res <= st_next;
    end
  end

  dotc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dotc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (in_item),
    .cfg     (cfg),
    .st_next (st_next)
  );

  assign m_axis_tdata = {6'd0, res.door_ones, res.door_tens, res.door_min, res.mode,
                         res.cursor, res.set_done, res.sec, res.pm, res.min_ones,
                         res.min_tens, res.hour};

endmodule

`default_nettype wire

// ===== sim/tb_door_open_timeout_clock.sv =====
`timescale 1ns / 1ps

module tb_door_open_timeout_clock;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  // result fields as packed in m_axis_tdata, highest bits first
  typedef struct packed {
    logic [5:0] fill;
    logic [3:0] door_ones;
    logic [2:0] door_tens;
    logic [3:0] door_min;
    logic [1:0] mode;
    logic [1:0] cursor;
    logic       valid;
    logic [5:0] sec;
    logic       pm;
    logic [3:0] ones;
    logic [2:0] tens;
    logic [3:0] hour;
  } clock_view_t;

  typedef struct packed {
    logic                   set;
    logic [3:0]             hr;
    logic [2:0]             tens;
    logic [3:0]             ones;
    logic                   pm;
    logic [5:0]             sec;
    dotc_pkg::dotc_cursor_t cur;
    dotc_pkg::dotc_mode_t   mode;
    logic [3:0]             om;
    logic [2:0]             ot;
    logic [3:0]             oo;
    logic [5:0]             cc;
  } door_clock_t;

  typedef struct {
    dotc_pkg::dotc_req_t kind;
    logic [7:0]          lvl;
    bit                  typed;
    clock_view_t         want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [dotc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dotc_pkg::ADDR_W-1:0] paddr = '0;
  logic [dotc_pkg::DATA_W-1:0] pwdata = '0;
  logic [dotc_pkg::DATA_W-1:0] prdata;
  logic pready;

  door_clock_t door_clock;
  dotc_pkg::dotc_cfg_t cfg;
  clock_view_t pending_views[$];
  table_row_t steps_tbl[$];
  clock_view_t seen_view, want_view;
  int fails = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_style = 0;
  int rx_left = 0;

  door_open_timeout_clock dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic clock_view_t setup_view(logic [3:0] hr, logic [2:0] tens,
                                             logic [3:0] ones, logic pm,
                                             dotc_pkg::dotc_cursor_t cur);
    clock_view_t v;
    v = '0;
    v.hour = hr;
    v.tens = tens;
    v.ones = ones;
    v.pm = pm;
    v.cursor = cur;
    return v;
  endfunction

  function automatic void step_field(bit up);
    case (door_clock.cur)
      dotc_pkg::CUR_HOUR: begin
        if (up) door_clock.hr = (door_clock.hr >= 12) ? 4'd1 : door_clock.hr + 4'd1;
        else door_clock.hr = (door_clock.hr <= 1 || door_clock.hr > 12) ? 4'd12
                                                                        : door_clock.hr - 4'd1;
      end
      dotc_pkg::CUR_TENS: begin
        if (up) door_clock.tens = (door_clock.tens >= 5) ? 3'd0 : door_clock.tens + 3'd1;
        else door_clock.tens = (door_clock.tens == 0 || door_clock.tens > 5) ? 3'd5
                                                                            : door_clock.tens - 3'd1;
      end
      dotc_pkg::CUR_ONES: begin
        if (up) door_clock.ones = (door_clock.ones >= 9) ? 4'd0 : door_clock.ones + 4'd1;
        else door_clock.ones = (door_clock.ones == 0 || door_clock.ones > 9) ? 4'd9
                                                                            : door_clock.ones - 4'd1;
      end
      default: door_clock.pm = ~door_clock.pm;
    endcase
  endfunction

  function automatic clock_view_t apply_item(dotc_pkg::dotc_req_t kind, logic [7:0] lvl);
    clock_view_t v;
    if (kind == dotc_pkg::REQ_SAMPLE && !door_clock.set) begin
      if (lvl > dotc_pkg::LVL_NONE) begin
      end else if (lvl > dotc_pkg::LVL_SELECT) begin
        door_clock.set = 1'b1;
      end else if (lvl > dotc_pkg::LVL_LEFT) begin
        if (door_clock.cur != dotc_pkg::CUR_HOUR)
          door_clock.cur = dotc_pkg::dotc_cursor_t'(door_clock.cur - 2'd1);
      end else if (lvl > dotc_pkg::LVL_DOWN) begin
        step_field(1'b0);
      end else if (lvl > dotc_pkg::LVL_UP) begin
        step_field(1'b1);
      end else begin
        if (door_clock.cur != dotc_pkg::CUR_HALF)
          door_clock.cur = dotc_pkg::dotc_cursor_t'(door_clock.cur + 2'd1);
      end
    end else if (kind == dotc_pkg::REQ_SAMPLE) begin
      if (door_clock.mode != dotc_pkg::MODE_CLOSING) begin
        if (door_clock.hr >= cfg.win_start && door_clock.hr <= cfg.win_end &&
            door_clock.pm == cfg.win_pm)
          door_clock.mode = (lvl > cfg.closed_level) ? dotc_pkg::MODE_IDLE
                                                     : dotc_pkg::MODE_OPEN;
        else
          door_clock.mode = dotc_pkg::MODE_IDLE;
      end
    end else if (door_clock.set) begin
      door_clock.sec = door_clock.sec + 6'd1;
      if (door_clock.sec >= 60) begin
        door_clock.sec = 6'd0;
        door_clock.ones = door_clock.ones + 4'd1;
        if (door_clock.ones >= 10) begin
          door_clock.ones = 4'd0;
          if (door_clock.tens < 5) begin
            door_clock.tens = door_clock.tens + 3'd1;
          end else begin
            door_clock.tens = 3'd0;
            door_clock.hr = door_clock.hr + 4'd1;
            if (door_clock.hr == 12) door_clock.pm = ~door_clock.pm;
            else if (door_clock.hr > 12) door_clock.hr = 4'd1;
          end
        end
      end
      if (door_clock.mode == dotc_pkg::MODE_OPEN) begin
        door_clock.oo = door_clock.oo + 4'd1;
        if (door_clock.oo >= 10) begin
          door_clock.oo = 4'd0;
          door_clock.ot = door_clock.ot + 3'd1;
          if (door_clock.ot >= 6) begin
            door_clock.ot = 3'd0;
            if (int'(door_clock.om) + 1 >= int'(cfg.open_limit) || door_clock.om >= 9) begin
              door_clock.mode = dotc_pkg::MODE_CLOSING;
              door_clock.cc = 6'd0;
              door_clock.om = 4'd0;
              door_clock.oo = 4'd0;
            end else begin
              door_clock.om = door_clock.om + 4'd1;
            end
          end
        end
      end else begin
        door_clock.om = 4'd0;
        door_clock.ot = 3'd0;
        door_clock.oo = 4'd0;
        if (door_clock.mode == dotc_pkg::MODE_CLOSING) begin
          if (door_clock.cc < 63) door_clock.cc = door_clock.cc + 6'd1;
          if (door_clock.cc >= cfg.close_dur) begin
            door_clock.mode = dotc_pkg::MODE_IDLE;
            door_clock.cc = 6'd0;
          end
        end
      end
    end
    v = '0;
    v.hour = door_clock.hr;
    v.tens = door_clock.tens;
    v.ones = door_clock.ones;
    v.pm = door_clock.pm;
    v.sec = door_clock.sec;
    v.valid = door_clock.set;
    v.cursor = door_clock.cur;
    v.mode = door_clock.mode;
    v.door_min = door_clock.om;
    v.door_tens = door_clock.ot;
    v.door_ones = door_clock.oo;
    return v;
  endfunction

  task automatic send_request(dotc_pkg::dotc_req_t kind, logic [7:0] lvl, bit typed,
                              clock_view_t want);
    clock_view_t predicted;
    int gap;
    predicted = apply_item(kind, lvl);
    pending_views.push_back(typed ? want : predicted);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= lvl;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(40, 0);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(dotc_pkg::dotc_reg_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic door_phase(logic [3:0] first, logic [3:0] last, logic pm,
                            logic [7:0] lvl, logic [3:0] lim, logic [5:0] dur,
                            int n, int tick_pct, bit squeeze);
    logic [7:0] sample;
    int pick;
    drain_results();
    write_reg(dotc_pkg::REG_WIN_START, 32'(first));
    write_reg(dotc_pkg::REG_WIN_END, 32'(last));
    write_reg(dotc_pkg::REG_WIN_PM, 32'(pm));
    write_reg(dotc_pkg::REG_CLOSED_LVL, 32'(lvl));
    write_reg(dotc_pkg::REG_OPEN_LIMIT, 32'(lim));
    write_reg(dotc_pkg::REG_CLOSE_DUR, 32'(dur));
    cfg.win_start = first;
    cfg.win_end = last;
    cfg.win_pm = pm;
    cfg.closed_level = lvl;
    cfg.open_limit = lim;
    cfg.close_dur = dur;
    if (squeeze) hold_asks <= hold_asks + 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        send_request(dotc_pkg::REQ_TICK, 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        pick = $urandom_range(9);
        if (pick < 6) sample = 8'($urandom_range(cfg.closed_level, 0));
        else if (pick < 8) sample = 8'($urandom_range(255));
        else sample = cfg.closed_level + 8'(pick - 8);
        send_request(dotc_pkg::REQ_SAMPLE, sample, 1'b0, '0);
      end
    end
  endtask

  // receiver: changing stall styles, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_served <= hold_served + 1;
    end else if (hold_served != hold_asks) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (rx_left == 0) begin
        rx_style <= $urandom_range(3);
        rx_left <= $urandom_range(300, 20);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(1));
        2: m_axis_tready <= ($urandom_range(3) == 0);
        default: m_axis_tready <= (cycles % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_view = clock_view_t'(m_axis_tdata);
      if (pending_views.size() == 0) begin
        fails++;
        $display("%0t unexpected result, actual %h", $time, m_axis_tdata);
      end else begin
        want_view = pending_views.pop_front();
        if (seen_view !== want_view) begin
          fails++;
          $display("%0t mismatch expected h%0d t%0d o%0d pm%0d s%0d v%0d c%0d m%0d %0d:%0d%0d f%0h",
                   $time, want_view.hour, want_view.tens, want_view.ones, want_view.pm,
                   want_view.sec, want_view.valid, want_view.cursor, want_view.mode,
                   want_view.door_min, want_view.door_tens, want_view.door_ones,
                   want_view.fill);
          $display("%0t          actual   h%0d t%0d o%0d pm%0d s%0d v%0d c%0d m%0d %0d:%0d%0d f%0h",
                   $time, seen_view.hour, seen_view.tens, seen_view.ones, seen_view.pm,
                   seen_view.sec, seen_view.valid, seen_view.cursor, seen_view.mode,
                   seen_view.door_min, seen_view.door_tens, seen_view.door_ones,
                   seen_view.fill);
        end
      end
    end
  end

  initial begin
    table_row_t row;
    logic [7:0] lvl;
    door_clock = '0;
    door_clock.hr = 4'd1;
    cfg.win_start = 4'd6;
    cfg.win_end = 4'd10;
    cfg.win_pm = 1'b0;
    cfg.closed_level = 8'd130;
    cfg.open_limit = 4'd10;
    cfg.close_dur = 6'd5;

    // set mode walk: no-button levels, each direction button at its edges, wraps, cursor ends
    steps_tbl.push_back('{dotc_pkg::REQ_TICK, 8'd0, 1'b1,
                          setup_view(1, 0, 0, 0, dotc_pkg::CUR_HOUR)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd255, 1'b1,
                          setup_view(1, 0, 0, 0, dotc_pkg::CUR_HOUR)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd231, 1'b1,
                          setup_view(1, 0, 0, 0, dotc_pkg::CUR_HOUR)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd180, 1'b1,
                          setup_view(1, 0, 0, 0, dotc_pkg::CUR_HOUR)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd0, 1'b1,
                          setup_view(1, 0, 0, 0, dotc_pkg::CUR_TENS)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd30, 1'b1,
                          setup_view(1, 0, 0, 0, dotc_pkg::CUR_ONES)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd31, 1'b1,
                          setup_view(1, 0, 1, 0, dotc_pkg::CUR_ONES)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd80, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd81, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd130, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd100, 1'b1,
                          setup_view(1, 0, 9, 0, dotc_pkg::CUR_ONES)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd50, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd131, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd100, 1'b1,
                          setup_view(1, 5, 0, 0, dotc_pkg::CUR_TENS)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd50, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd160, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd100, 1'b1,
                          setup_view(12, 0, 0, 0, dotc_pkg::CUR_HOUR)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd50, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd0, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd10, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd20, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd0, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd50, 1'b1,
                          setup_view(1, 0, 0, 1, dotc_pkg::CUR_HALF)});
    steps_tbl.push_back('{dotc_pkg::REQ_SAMPLE, 8'd100, 1'b0, '0});
    steps_tbl.push_back('{dotc_pkg::REQ_TICK, 8'd255, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (steps_tbl[i]) begin
      row = steps_tbl[i];
      send_request(row.kind, row.lvl, row.typed, row.want);
    end

    // random buttons and ignored ticks before the clock is set
    repeat (200) begin
      if ($urandom_range(3) == 0) begin
        send_request(dotc_pkg::REQ_TICK, 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        do lvl = 8'($urandom_range(255));
        while (lvl > dotc_pkg::LVL_SELECT && lvl <= dotc_pkg::LVL_NONE);
        send_request(dotc_pkg::REQ_SAMPLE, lvl, 1'b0, '0);
      end
    end

    // set 11:59 am so the first minute rolls into pm
    repeat (3) send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(180, 131)), 1'b0, '0);
    while (door_clock.hr != 4'd11)
      send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(130, 81)), 1'b0, '0);
    send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(30, 0)), 1'b0, '0);
    while (door_clock.tens != 3'd5)
      send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(80, 31)), 1'b0, '0);
    send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(30, 0)), 1'b0, '0);
    while (door_clock.ones != 4'd9)
      send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(80, 31)), 1'b0, '0);
    send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(30, 0)), 1'b0, '0);
    if (door_clock.pm)
      send_request(dotc_pkg::REQ_SAMPLE, 8'($urandom_range(80, 31)), 1'b0, '0);
    send_request(dotc_pkg::REQ_SAMPLE, 8'd230, 1'b0, '0);

    door_phase(4'd11, 4'd11, 1'b0, 8'd130, 4'd1, 6'd1, 120, 80, 1'b0);
    door_phase(4'd1, 4'd12, door_clock.pm, 8'd0, 4'd1, 6'd63, 250, 80, 1'b0);
    door_phase(4'd12, 4'd12, 1'b1, 8'd255, 4'd2, 6'd0, 150, 85, 1'b0);
    door_phase(4'd1, 4'd12, door_clock.pm, 8'($urandom_range(255)), 4'd0,
               6'($urandom_range(5, 1)), 200, 80, 1'b0);
    door_phase(4'd9, 4'd3, door_clock.pm, 8'($urandom_range(255)), 4'd10, 6'd5, 80, 70, 1'b0);
    // door held open past the ten-minute cap, with a long output stall
    door_phase(4'd1, 4'd12, door_clock.pm, 8'd255, 4'd15, 6'd3, 760, 92, 1'b1);
    door_phase(4'd14, 4'd15, ~door_clock.pm, 8'($urandom_range(255)), 4'd10, 6'd5,
               80, 70, 1'b0);
    repeat (2)
      door_phase(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), 4'($urandom_range(15)), 6'($urandom_range(63)),
                 120, 80, 1'b0);

    drain_results();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dotc_pkg.sv
hw/rtl/dotc_cfg.sv
hw/rtl/dotc_core.sv
hw/rtl/door_open_timeout_clock.sv
sim/tb_door_open_timeout_clock.sv
